// ===== rtl/gfpe_pkg.sv =====
// Shared types, constants and field arithmetic of the GF(2^8) erasure parity encoder.
package gfpe_pkg;

  localparam int unsigned MAX_PARITY   = 16;
  localparam int unsigned MAX_SEGMENTS = 256;
  localparam int unsigned VECTOR_MAX   = 2048;
  localparam int unsigned CODE_LIMIT   = 255;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned PIDX_W   = 4;
  localparam int unsigned SEG_W    = 8;
  localparam int unsigned OFF_W    = 11;
  localparam int unsigned DCNT_W   = 8;
  localparam int unsigned PCNT_W   = 5;
  localparam int unsigned VLEN_W   = 12;
  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned STAT_W   = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 12;
  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 16;

  localparam logic [BYTE_W:0] FIELD_POLY = 9'h11D;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD = 2'd0,
    FUNC_DATA = 2'd1,
    FUNC_READ = 2'd2
  } func_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_BAD_CFG = 2'd1,
    STAT_RANGE   = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DATA_COUNT    = 2'd0,
    CFG_PARITY_COUNT  = 2'd1,
    CFG_VECTOR_LENGTH = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_e;

  typedef logic [MAX_PARITY-1:0][BYTE_W-1:0] pword_t;

  typedef struct packed {
    pword_t              parity;
    pword_t              coefs;
    logic [BYTE_W-1:0]   value;
    logic [PCNT_W-1:0]   lanes;
  } mac_req_t;

  function automatic logic [BYTE_W-1:0] gf_mul(input logic [BYTE_W-1:0] a,
                                               input logic [BYTE_W-1:0] b);
    logic [BYTE_W:0]   x;
    logic [BYTE_W-1:0] acc;
    x   = {1'b0, a};
    acc = '0;
    for (int i = 0; i < BYTE_W; i++) begin
      if (b[i]) begin
        acc = acc ^ x[BYTE_W-1:0];
      end
      x = {x[BYTE_W-1:0], 1'b0};
      if (x[BYTE_W]) begin
        x = x ^ FIELD_POLY;
      end
    end
    return acc;
  endfunction

endpackage

// ===== rtl/gfpe_parity_mac.sv =====
// Parallel GF(2^8) multiply-accumulate over the parity lanes below lanes of one parity word; other lanes pass through.
module gfpe_parity_mac (
  input  gfpe_pkg::mac_req_t req_i,
  output gfpe_pkg::pword_t   parity_o
);
  import gfpe_pkg::*;

  always_comb begin
    for (int p = 0; p < MAX_PARITY; p++) begin
      if (PCNT_W'(p) < req_i.lanes) begin
        parity_o[p] = req_i.parity[p] ^ gf_mul(req_i.coefs[p], req_i.value);
      end else begin
        parity_o[p] = req_i.parity[p];
      end
    end
  end

endmodule

// ===== rtl/gf256_erasure_parity_encoder.sv =====
// Top level of the GF(2^8) Reed-Solomon erasure parity encoder.
//
//  channel  direction  handshake                    payload
//  s_axis   in         s_axis_tvalid/s_axis_tready  tuser func, tdata item fields
//  m_axis   out        m_axis_tvalid/m_axis_tready  tdata parity_byte, status
//  cfg      in         cfg_valid_i/cfg_ready_o      cfg_index_i, cfg_data_i
//
// In the accept cycle the coefficient row and the parity word are read from their
// one-port memories into registers; the result is written back in the execute state.
// After reset a clearing pass zeroes the whole parity memory, one word a cycle;
// no item is taken meanwhile, configuration writes always are.
// A result waiting in the output register does not block the next accept; only the
// write-back cycle waits for the output register to free up.
module gf256_erasure_parity_encoder (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [3:0] parity_index, [11:4] segment_index, [22:12] byte_offset, [30:23] byte_value
  input  logic [gfpe_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  // [1:0] func
  input  logic [gfpe_pkg::FUNC_W-1:0]          s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [7:0] parity_byte, [9:8] status
  output logic [gfpe_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [gfpe_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [gfpe_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import gfpe_pkg::*;

  logic [DCNT_W-1:0] dcnt_q;
  logic [PCNT_W-1:0] pcnt_q;
  logic [VLEN_W-1:0] vlen_q;
  logic              cfg_bad;

  state_e state_q, state_d;
  logic [OFF_W-1:0] clr_q, clr_d;

  logic                in_acc;
  logic [PIDX_W-1:0]   in_pidx;
  logic [SEG_W-1:0]    in_seg;
  logic [OFF_W-1:0]    in_off;
  logic [BYTE_W-1:0]   in_val;
  status_e             in_stat;

  func_e               func_q;
  logic [PIDX_W-1:0]   pidx_q;
  logic [SEG_W-1:0]    seg_q;
  logic [OFF_W-1:0]    off_q;
  logic [BYTE_W-1:0]   val_q;
  status_e             stat_q;

  pword_t coef_mem [MAX_SEGMENTS];
  pword_t par_mem  [VECTOR_MAX];
  pword_t coef_rd_q;
  pword_t par_rd_q;

  logic              advance;
  logic              coef_we;
  logic              par_we;
  logic [OFF_W-1:0]  par_waddr;
  pword_t            par_wdata;
  pword_t            par_cleared;
  pword_t            mac_out;
  mac_req_t          mac_req;
  logic [BYTE_W-1:0] res_byte;

  logic                  out_valid_q, out_valid_d;
  logic [OUT_DATA_W-1:0] out_data_q, out_data_d;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dcnt_q <= DCNT_W'(1);
      pcnt_q <= PCNT_W'(1);
      vlen_q <= VLEN_W'(VECTOR_MAX);
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_DATA_COUNT:    dcnt_q <= cfg_data_i[DCNT_W-1:0];
        CFG_PARITY_COUNT:  pcnt_q <= cfg_data_i[PCNT_W-1:0];
        CFG_VECTOR_LENGTH: vlen_q <= cfg_data_i[VLEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_bad = (dcnt_q == '0)
                 || ({1'b0, dcnt_q} > (DCNT_W+1)'(MAX_SEGMENTS))
                 || (pcnt_q > PCNT_W'(MAX_PARITY))
                 || (({1'b0, dcnt_q} + (DCNT_W+1)'(pcnt_q)) > (DCNT_W+1)'(CODE_LIMIT))
                 || (vlen_q == '0)
                 || (vlen_q > VLEN_W'(VECTOR_MAX));

  assign in_pidx = s_axis_tdata[PIDX_W-1:0];
  assign in_seg  = s_axis_tdata[PIDX_W +: SEG_W];
  assign in_off  = s_axis_tdata[PIDX_W+SEG_W +: OFF_W];
  assign in_val  = s_axis_tdata[PIDX_W+SEG_W+OFF_W +: BYTE_W];

  always_comb begin
    in_stat = STAT_OK;
    if (cfg_bad) begin
      in_stat = STAT_BAD_CFG;
    end else begin
      case (func_e'(s_axis_tuser))
        FUNC_LOAD: begin
          if ((PCNT_W'(in_pidx) >= pcnt_q) || (in_seg >= dcnt_q)) in_stat = STAT_RANGE;
        end
        FUNC_DATA: begin
          if ((in_seg >= dcnt_q) || (VLEN_W'(in_off) >= vlen_q)) in_stat = STAT_RANGE;
        end
        FUNC_READ: begin
          if ((PCNT_W'(in_pidx) >= pcnt_q) || (VLEN_W'(in_off) >= vlen_q)) begin
            in_stat = STAT_RANGE;
          end
        end
        default: in_stat = STAT_RANGE;
      endcase
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign advance       = (state_q == ST_EXEC) && (!out_valid_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + OFF_W'(1);
        if (clr_q == OFF_W'(VECTOR_MAX - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (advance) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      func_q    <= func_e'(s_axis_tuser);
      pidx_q    <= in_pidx;
      seg_q     <= in_seg;
      off_q     <= in_off;
      val_q     <= in_val;
      stat_q    <= in_stat;
      coef_rd_q <= coef_mem[in_seg];
      par_rd_q  <= par_mem[in_off];
    end
  end

  assign mac_req = '{parity: par_rd_q, coefs: coef_rd_q, value: val_q, lanes: pcnt_q};

  gfpe_parity_mac u_mac (
    .req_i    (mac_req),
    .parity_o (mac_out)
  );

  always_comb begin
    par_cleared         = par_rd_q;
    par_cleared[pidx_q] = '0;
  end

  always_comb begin
    coef_we   = 1'b0;
    par_we    = 1'b0;
    par_waddr = off_q;
    par_wdata = mac_out;
    res_byte  = '0;
    if (state_q == ST_CLEAR) begin
      par_we    = 1'b1;
      par_waddr = clr_q;
      par_wdata = '0;
    end else if (advance && (stat_q == STAT_OK)) begin
      case (func_q)
        FUNC_LOAD: coef_we = 1'b1;
        FUNC_DATA: par_we  = 1'b1;
        FUNC_READ: begin
          par_we    = 1'b1;
          par_wdata = par_cleared;
          res_byte  = par_rd_q[pidx_q];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (coef_we) begin
      coef_mem[seg_q][pidx_q] <= val_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (par_we) begin
      par_mem[par_waddr] <= par_wdata;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (advance) begin
      out_valid_d = 1'b1;
      out_data_d  = {(OUT_DATA_W-BYTE_W-STAT_W)'(0), stat_q, res_byte};
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule
